// File: sv/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants for the deadline timer scheduler
// Holds opcode and result codes, field widths and the cell control struct.
// ----------------------------------------------------------------------------
package dts_pkg;

   localparam int TIME_W = 48;
   localparam int ID_W   = 32;
   localparam int AMT_W  = 32;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef enum logic [1:0] {
      OP_ONESHOT  = 2'd0,
      OP_PERIODIC = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_ADVANCE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      RK_ASSIGNED = 2'd0,
      RK_FIRED    = 2'd1,
      RK_DONE     = 2'd2,
      RK_FULL     = 2'd3
   } result_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_EMIT,
      ST_FINISH,
      ST_WAIT
   } state_type;

   // Candidate passed along the search chain.
   typedef struct packed {
      logic              found;
      logic [TIME_W-1:0] due;
      logic [ID_W-1:0]   order;
      logic [7:0]        slot;
   } cand_type;

   // Commands broadcast from the sequencer to every cell.
   typedef struct packed {
      logic              write;       // arm the cell selected by sel
      logic              fire;        // fire the cell selected by sel
      logic              clear;       // drop cells holding target
      logic [7:0]        sel;
      logic [ID_W-1:0]   target;
      logic [ID_W-1:0]   ident;
      logic [TIME_W-1:0] due;
      logic [ID_W-1:0]   period;
      logic [ID_W-1:0]   order;
   } cell_cmd_type;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [ID_W-1:0] b);
      logic [TIME_W:0] s;
      begin
         s = {1'b0, a} + {{(TIME_W-ID_W+1){1'b0}}, b};
         sat_add = s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
      end
   endfunction

endpackage

// File: sv/dts_if.sv
// ----------------------------------------------------------------------------
// dts_req_if / dts_rsp_if: valid/ready channels of the timer scheduler
// Request and result item channels with source and sink modports.
// ----------------------------------------------------------------------------
interface dts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic signed [31:0] amount;
   logic [31:0] target_id;
   modport source (output valid, opcode, amount, target_id, input ready);
   modport sink   (input valid, opcode, amount, target_id, output ready);
endinterface

interface dts_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] timer_ref;
   logic [47:0] event_time;
   logic        more_pending;
   logic        last;
   modport source (output valid, result_kind, timer_ref, event_time, more_pending, last,
                   input ready);
   modport sink   (input valid, result_kind, timer_ref, event_time, more_pending, last,
                   output ready);
endinterface

// File: sv/dts_cell.sv
// ----------------------------------------------------------------------------
// dts_cell: one timer slot of the chain
// Holds one timer and merges it into the earliest-deadline candidate.
// ----------------------------------------------------------------------------
module dts_cell
   import dts_pkg::*;
#(
   parameter int SLOT = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  cand_type     cand_prev,
   output cand_type     cand_next,
   output logic         busy
);
   localparam logic [7:0] MY_SLOT = 8'(SLOT);

   logic              valid_ff, valid_in;
   logic [ID_W-1:0]   ident_ff;
   logic [TIME_W-1:0] due_ff;
   logic [ID_W-1:0]   period_ff;
   logic [ID_W-1:0]   order_ff;
   logic              mine;

   assign mine = (cmd.sel == MY_SLOT);
   assign busy = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.write && mine) begin
         valid_in = 1'b1;
      end else if (cmd.fire && mine && period_ff == '0) begin
         valid_in = 1'b0;
      end else if (cmd.clear && cmd.target != '0 && ident_ff == cmd.target) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (cmd.write && mine) begin
         ident_ff  <= cmd.ident;
         due_ff    <= cmd.due;
         period_ff <= cmd.period;
         order_ff  <= cmd.order;
      end else if (cmd.fire && mine) begin
         due_ff   <= sat_add(due_ff, period_ff);
         order_ff <= cmd.order;
      end
   end

   // Take over the candidate only on a strictly better key: ties keep lower slot.
   always_comb begin
      cand_next = cand_prev;
      if (valid_ff && (!cand_prev.found || due_ff < cand_prev.due ||
          (due_ff == cand_prev.due && order_ff < cand_prev.order))) begin
         cand_next.found = 1'b1;
         cand_next.due   = due_ff;
         cand_next.order = order_ff;
         cand_next.slot  = MY_SLOT;
      end
   end

endmodule

// File: sv/dts_chain.sv
// ----------------------------------------------------------------------------
// dts_chain: row of timer cells with a registered candidate every stage
// The candidate walks one cell per cycle; identifiers are read by slot index.
// ----------------------------------------------------------------------------
module dts_chain
   import dts_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  cell_cmd_type    cmd,
   output cand_type        result,     // candidate leaving the last cell
   output logic [SLOTS-1:0] busy
);
   cand_type stage_ff [SLOTS];
   cand_type comb_out [SLOTS];
   cand_type empty_c;

   assign empty_c = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      dts_cell #(.SLOT(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .cand_prev((i == 0) ? empty_c : stage_ff[(i == 0) ? 0 : i-1]),
         .cand_next(comb_out[i]),
         .busy     (busy[i])
      );
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         stage_ff[i] <= comb_out[i];
      end
   end

   assign result = stage_ff[SLOTS-1];

endmodule

// File: sv/deadline_timer_scheduler.sv
// ----------------------------------------------------------------------------
// deadline_timer_scheduler: earliest-deadline timer table
// Clears and requests go from idle to decide; an advance first searches, the
// candidate walking the cell chain one slot per search cycle, then fires due
// timers through emit and ends in finish. A request result is registered in
// the decide state after its item is accepted. One item at a time.
// Reset: all slots free, time 0, next id 1, next sequence 0.
// ----------------------------------------------------------------------------
module deadline_timer_scheduler
   import dts_pkg::*;
#(
   parameter int TIMER_SLOTS = 16,
   parameter int MAX_FIRES   = 63
) (
   input  logic   clock,
   input  logic   reset,
   dts_req_if.sink   req,
   dts_rsp_if.source rsp
);
   localparam int CNT_W  = $clog2(TIMER_SLOTS + 2);
   localparam int FC_W   = 6;
   localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

   state_type state_ff, state_in;
   logic [1:0]        op_ff;
   logic signed [AMT_W-1:0] amt_ff;
   logic [ID_W-1:0]   tgt_ff;
   logic [TIME_W-1:0] now_ff, end_ff;
   logic [ID_W-1:0]   nid_ff, nord_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [FC_W-1:0]   fires_ff;
   cand_type          best_ff;
   logic [ID_W-1:0]   fire_id;

   // Result register.
   logic              rv_ff, rv_set;
   logic [1:0]        rk_ff;
   logic [ID_W-1:0]   rref_ff;
   logic [TIME_W-1:0] rtime_ff;
   logic              rmore_ff, rlast_ff;

   cell_cmd_type      cmd;
   cand_type          chain_out;
   logic [TIMER_SLOTS-1:0] busy;
   logic [ID_W-1:0]   ident_tab [TIMER_SLOTS];
   logic [ID_W-1:0]   period_tab [TIMER_SLOTS];

   logic              full;
   logic [7:0]        free_slot;
   logic [ID_W-1:0]   arm_period;
   logic [TIME_W-1:0] arm_due;
   logic              chain_done, due_ok, fire_now;

   dts_chain #(.SLOTS(TIMER_SLOTS)) u_chain (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .result(chain_out),
      .busy  (busy)
   );

   // Mirror ident/period per slot for the fire result and re-arm test.
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         ident_tab[cmd.sel[SLOT_W-1:0]]  <= cmd.ident;
         period_tab[cmd.sel[SLOT_W-1:0]] <= cmd.period;
      end
   end

   always_comb begin
      free_slot = 8'(TIMER_SLOTS);
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!busy[i]) free_slot = 8'(i);
      end
   end
   assign full = &busy;

   always_comb begin
      if (op_ff == OP_PERIODIC) begin
         arm_period = (amt_ff < 1) ? ID_W'(1) : ID_W'(amt_ff);
         arm_due    = sat_add(now_ff, arm_period);
      end else begin
         arm_period = '0;
         arm_due    = sat_add(now_ff, (amt_ff < 0) ? '0 : ID_W'(amt_ff));
      end
   end

   assign fire_id    = ident_tab[best_ff.slot[SLOT_W-1:0]];
   assign chain_done = (cnt_ff == CNT_W'(TIMER_SLOTS));
   assign due_ok     = best_ff.found && best_ff.due <= end_ff;
   assign fire_now   = due_ok && (fires_ff < FC_W'(MAX_FIRES));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               state_in = (req.opcode == OP_ADVANCE) ? ST_SEARCH : ST_DECIDE;
            end
         end
         ST_SEARCH: if (chain_done) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (op_ff == OP_CLEAR) state_in = ST_IDLE;
            else if (op_ff != OP_ADVANCE) state_in = ST_WAIT;
            else if (fire_now) state_in = ST_EMIT;
            else state_in = ST_FINISH;
         end
         ST_EMIT:   if (!rv_ff || rsp.ready) state_in = ST_SEARCH;
         ST_FINISH: if (!rv_ff || rsp.ready) state_in = ST_WAIT;
         ST_WAIT:   if (!rv_ff || rsp.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Cell commands.
   always_comb begin
      cmd        = '0;
      cmd.sel    = free_slot;
      cmd.target = tgt_ff;
      cmd.ident  = nid_ff;
      cmd.due    = arm_due;
      cmd.period = arm_period;
      cmd.order  = nord_ff;
      case (state_ff)
         ST_DECIDE: begin
            cmd.clear = (op_ff == OP_CLEAR);
            cmd.write = (op_ff == OP_ONESHOT || op_ff == OP_PERIODIC) && !full;
         end
         ST_EMIT: begin
            cmd.sel  = best_ff.slot;
            cmd.fire = (!rv_ff || rsp.ready);
         end
         default: ;
      endcase
   end

   // Load a new result when a request decides or a fire/done goes out.
   always_comb begin
      case (state_ff)
         ST_DECIDE:           rv_set = (op_ff == OP_ONESHOT || op_ff == OP_PERIODIC);
         ST_EMIT, ST_FINISH:  rv_set = !rv_ff || rsp.ready;
         default:             rv_set = 1'b0;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         now_ff   <= '0;
         nid_ff   <= ID_W'(1);
         nord_ff  <= '0;
         rv_ff    <= 1'b0;
         cnt_ff   <= '0;
         fires_ff <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_set || (rv_ff && !rsp.ready);
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  op_ff    <= req.opcode;
                  amt_ff   <= req.amount;
                  tgt_ff   <= req.target_id;
                  end_ff   <= sat_add(now_ff, (req.amount < 0) ? '0 : ID_W'(req.amount));
                  cnt_ff   <= '0;
                  fires_ff <= '0;
               end
            end
            ST_SEARCH: begin
               cnt_ff <= chain_done ? '0 : cnt_ff + 1'b1;
               if (chain_done) best_ff <= chain_out;
            end
            ST_DECIDE: begin
               if (op_ff == OP_ONESHOT || op_ff == OP_PERIODIC) begin
                  rk_ff    <= full ? RK_FULL : RK_ASSIGNED;
                  rref_ff  <= full ? '0 : nid_ff;
                  rtime_ff <= now_ff;
                  rmore_ff <= 1'b0;
                  rlast_ff <= 1'b1;
                  if (!full) begin
                     nord_ff <= nord_ff + 1'b1;
                     nid_ff  <= (nid_ff == '1) ? ID_W'(1) : nid_ff + 1'b1;
                  end
               end
            end
            ST_EMIT: begin
               if (!rv_ff || rsp.ready) begin
                  now_ff   <= (best_ff.due > now_ff) ? best_ff.due : now_ff;
                  rk_ff    <= RK_FIRED;
                  rref_ff  <= fire_id;
                  rtime_ff <= (best_ff.due > now_ff) ? best_ff.due : now_ff;
                  rmore_ff <= 1'b0;
                  rlast_ff <= 1'b0;
                  fires_ff <= fires_ff + 1'b1;
                  if (period_tab[best_ff.slot[SLOT_W-1:0]] != '0) begin
                     nord_ff <= nord_ff + 1'b1;
                  end
               end
            end
            ST_FINISH: begin
               if (!rv_ff || rsp.ready) begin
                  now_ff   <= end_ff;
                  rk_ff    <= RK_DONE;
                  rref_ff  <= '0;
                  rtime_ff <= end_ff;
                  rmore_ff <= due_ok;
                  rlast_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid        = rv_ff;
   assign rsp.result_kind  = rk_ff;
   assign rsp.timer_ref    = rref_ff;
   assign rsp.event_time   = rtime_ff;
   assign rsp.more_pending = rmore_ff;
   assign rsp.last         = rlast_ff;

endmodule
